// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define HRBM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define HRBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/hrbm_pkg.sv -----
// shared widths and inter-module status types for the heart rate meter
`timescale 1ns / 1ps

package hrbm_pkg;

  localparam int COUNT_W    = 16;
  localparam int RATE_W     = 16;
  localparam int CMP_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic               beat;
    logic [COUNT_W-1:0] count;
  } det_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_st_t;

endpackage

// ----- sv/hrbm_sample_if.sv -----
// sample channel: valid, ready and one sensor sample
`timescale 1ns / 1ps

interface hrbm_sample_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- sv/hrbm_result_if.sv -----
// result channel: valid, ready and the rate and blink fields
`timescale 1ns / 1ps

interface hrbm_result_if;
  import hrbm_pkg::*;

  logic               valid;
  logic               ready;
  logic [RATE_W-1:0]  bpm;
  logic               beat;
  logic               pwm_update;
  logic [RATE_W-1:0]  pwm_prescaler;
  logic [CMP_W-1:0]   pwm_compare;
  logic               alarm;

  modport source (output valid, output bpm, output beat, output pwm_update,
                  output pwm_prescaler, output pwm_compare, output alarm, input ready);
  modport sink   (input valid, input bpm, input beat, input pwm_update,
                  input pwm_prescaler, input pwm_compare, input alarm, output ready);
endinterface

// ----- sv/heart_rate_beat_meter.sv -----
// top level: detector, serial divider, rate ring, running sum and blink band choice
//
//  channel   dir  handshake      payload
//  samples   in   valid/ready    sample
//  results   out  valid/ready    bpm, beat, pwm_update, pwm_prescaler, pwm_compare, alarm
//  wr_*      in   wr_en only     wr_index, wr_data
//
// an item without a beat is loaded straight into the output register; one with a beat
// goes through the rate, average and finish states, using the shared bit-serial divider
// which runs once for the rate and once for the ring average
// reset is synchronous; the ring reads as zero through per-entry valid bits
// samples.ready is high only in idle with the output register free or being taken
`timescale 1ns / 1ps
`include "assert_macros.svh"

module heart_rate_beat_meter #(
  parameter int RING_DEPTH  = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  hrbm_sample_if.sink                      samples,
  hrbm_result_if.source                    results,
  input  logic                             wr_en,
  input  logic [hrbm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [hrbm_pkg::CFG_DATA_W-1:0]  wr_data
);
  import hrbm_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int SUM_W = RATE_W + IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM = 3'd4;

  localparam logic [RATE_W-1:0] BAND_60  = 16'd60;
  localparam logic [RATE_W-1:0] BAND_90  = 16'd90;
  localparam logic [RATE_W-1:0] BAND_130 = 16'd130;
  localparam logic [RATE_W-1:0] BAND_170 = 16'd170;
  localparam logic [RATE_W-1:0] BAND_190 = 16'd190;

  localparam logic [RATE_W-1:0] PSC_SLOWEST = 16'd63999;
  localparam logic [RATE_W-1:0] PSC_SLOW    = 16'd31999;
  localparam logic [RATE_W-1:0] PSC_MID     = 16'd21332;
  localparam logic [RATE_W-1:0] PSC_FAST    = 16'd15999;
  localparam logic [RATE_W-1:0] PSC_FASTER  = 16'd12799;
  localparam logic [RATE_W-1:0] PSC_FASTEST = 16'd10666;

  localparam logic [CMP_W-1:0] CMP_NORMAL = 10'd500;
  localparam logic [CMP_W-1:0] CMP_ALARM  = 10'd1000;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RATE = 2'd1;
  localparam logic [1:0] ST_AVG  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // configuration
  logic [SAMPLE_BITS-1:0] high_threshold, low_threshold;
  logic [7:0]             bpm_floor, bpm_ceiling;
  logic [RATE_W-1:0]      rate_numerator;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= SAMPLE_BITS'(2148);
      low_threshold  <= SAMPLE_BITS'(1948);
      bpm_floor      <= 8'd30;
      bpm_ceiling    <= 8'd130;
      rate_numerator <= 16'd30000;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HIGH_TH:  high_threshold <= wr_data[SAMPLE_BITS-1:0];
        REG_LOW_TH:   low_threshold  <= wr_data[SAMPLE_BITS-1:0];
        REG_ALARM_LO: bpm_floor      <= wr_data[7:0];
        REG_ALARM_HI: bpm_ceiling    <= wr_data[7:0];
        REG_RATE_NUM: rate_numerator <= wr_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [1:0]        state;
  logic              out_valid;
  logic              out_free, out_load, out_beat;
  logic              in_fire;
  det_t              det;
  div_st_t           div_st;
  logic              div_start;
  logic [SUM_W-1:0]  div_dividend, div_quot;
  logic [RATE_W-1:0] div_divisor;

  logic [IDX_W-1:0]      write_index;
  logic [RING_DEPTH-1:0] ring_valid;
  logic [RATE_W-1:0]     ram_rdata, old_rate, new_rate;
  logic                  ring_we;
  logic [SUM_W-1:0]      sum, sum_next;
  logic [RATE_W-1:0]     bpm;

  assign out_free      = !out_valid || results.ready;
  assign samples.ready = (state == ST_IDLE) && out_free;
  assign in_fire       = samples.valid && samples.ready;

  hrbm_detect #(.SAMPLE_BITS(SAMPLE_BITS)) u_detect (
    .clk            (clk),
    .rst            (rst),
    .fire           (in_fire),
    .sample         (samples.sample),
    .high_threshold (high_threshold),
    .low_threshold  (low_threshold),
    .det            (det)
  );

  // rate first, then the ring average, through the same divider
  assign ring_we      = (state == ST_RATE) && div_st.done;
  assign div_start    = (in_fire && det.beat) || ring_we;
  assign div_dividend = (state == ST_IDLE) ? SUM_W'(rate_numerator) : sum_next;
  assign div_divisor  = (state == ST_IDLE) ? det.count : RATE_W'(RING_DEPTH);

  hrbm_serdiv #(.DVD_W(SUM_W), .DVS_W(RATE_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .st       (div_st)
  );

  hrbm_ram #(.WIDTH(RATE_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_index),
    .wdata (new_rate),
    .raddr (write_index),
    .rdata (ram_rdata)
  );

  assign new_rate = div_quot[RATE_W-1:0];
  assign old_rate = ring_valid[write_index] ? ram_rdata : '0;
  assign sum_next = sum - SUM_W'(old_rate) + SUM_W'(new_rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_index <= '0;
      ring_valid  <= '0;
      sum         <= '0;
      bpm         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire && det.beat) state <= ST_RATE;
        end
        ST_RATE: begin
          if (div_st.done) begin
            ring_valid[write_index] <= 1'b1;
            write_index <= (write_index == IDX_LAST) ? '0 : write_index + 1'b1;
            sum         <= sum_next;
            state       <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_st.done) begin
            bpm   <= div_quot[RATE_W-1:0];
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // blink band from the current average
  logic              band_update, band_alarm;
  logic [RATE_W-1:0] band_psc;
  logic [CMP_W-1:0]  band_cmp;

  always_comb begin
    band_alarm = bpm > RATE_W'(bpm_ceiling);
    band_psc   = '0;
    band_cmp   = '0;
    if (band_alarm) begin
      band_psc = PSC_FASTEST;
      band_cmp = CMP_ALARM;
    end else begin
      if (({1'b0, bpm} + 17'd1 >= 17'(bpm_floor)) && bpm < BAND_60) band_psc = PSC_SLOWEST;
      else if (bpm >= BAND_60 && bpm < BAND_90)                     band_psc = PSC_SLOW;
      else if (bpm > BAND_90 && bpm <= BAND_130)                    band_psc = PSC_MID;
      else if (bpm > BAND_130 && bpm <= BAND_170)                   band_psc = PSC_FAST;
      else if (bpm > BAND_170 && bpm <= BAND_190)                   band_psc = PSC_FASTER;
      else if (bpm > BAND_190)                                      band_psc = PSC_FASTEST;
      if (band_psc != '0) band_cmp = CMP_NORMAL;
    end
    band_update = band_alarm || (band_psc != '0);
  end

  // output register
  assign out_load = (in_fire && !det.beat) || ((state == ST_FIN) && out_free);
  assign out_beat = (state == ST_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.bpm           <= bpm;
      results.beat          <= out_beat;
      results.pwm_update    <= band_update;
      results.pwm_prescaler <= band_psc;
      results.pwm_compare   <= band_cmp;
      results.alarm         <= band_alarm;
    end
  end

  assign results.valid = out_valid;

  `HRBM_ASSERT_IMP(a_div_idle_on_start, div_start, !div_st.busy, "divider restarted while busy")
  `HRBM_ASSERT_IMP(a_out_no_overwrite, out_load, !out_valid || results.ready, "result overwritten")
  `HRBM_ASSERT_IMP(a_rate_from_accept, state == ST_RATE && $past(state) == ST_IDLE,
                   $past(samples.valid && samples.ready), "rate division without an item")
  `HRBM_ASSERT(a_sum_bounded, {1'b0, sum} < ((SUM_W+1)'(RING_DEPTH) << RATE_W),
               "ring sum out of range")

endmodule

// ----- sv/hrbm_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module hrbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/hrbm_detect.sv -----
// four-phase hysteresis detector with saturating period counter
`timescale 1ns / 1ps

module hrbm_detect #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] high_threshold,
  input  logic [SAMPLE_BITS-1:0] low_threshold,
  output hrbm_pkg::det_t         det
);
  import hrbm_pkg::*;

  localparam logic [1:0] PH_WAIT_RISE  = 2'd0;
  localparam logic [1:0] PH_WAIT_FALL  = 2'd1;
  localparam logic [1:0] PH_COUNT_LOW  = 2'd2;
  localparam logic [1:0] PH_COUNT_HIGH = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [1:0]         phase, phase_next;
  logic [COUNT_W-1:0] period_count, period_count_next;
  logic [COUNT_W-1:0] count_inc;
  logic               risen, fallen;

  assign count_inc = (period_count == COUNT_MAX) ? COUNT_MAX : period_count + 1'b1;
  assign risen     = sample > high_threshold;
  assign fallen    = sample < low_threshold;

  always_comb begin
    phase_next        = phase;
    period_count_next = period_count;
    det.beat          = 1'b0;
    det.count         = count_inc;
    unique case (phase)
      PH_WAIT_RISE: begin
        if (risen) phase_next = PH_WAIT_FALL;
      end
      PH_WAIT_FALL: begin
        if (fallen) begin
          phase_next        = PH_COUNT_LOW;
          period_count_next = '0;
        end
      end
      PH_COUNT_LOW: begin
        period_count_next = count_inc;
        if (risen) phase_next = PH_COUNT_HIGH;
      end
      PH_COUNT_HIGH: begin
        period_count_next = count_inc;
        if (fallen) begin
          phase_next = PH_COUNT_LOW;
          if (count_inc != '0) begin
            det.beat          = 1'b1;
            period_count_next = '0;
          end
        end
      end
      default: phase_next = PH_WAIT_RISE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_RISE;
      period_count <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      period_count <= period_count_next;
    end
  end

endmodule

// ----- sv/hrbm_serdiv.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module hrbm_serdiv #(
  parameter int DVD_W = 19,
  parameter int DVS_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [DVS_W-1:0]   divisor,
  output logic [DVD_W-1:0]   quotient,
  output hrbm_pkg::div_st_t  st
);
  import hrbm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic [DVD_W-1:0] dq;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy, done;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh   = {rem, dq[DVD_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = dq;
  assign st.busy  = busy;
  assign st.done  = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dvs <= divisor;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      dq  <= {dq[DVD_W-2:0], ge};
      rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for heart_rate_beat_meter: random sample stream, random idling, scoreboard checks
`timescale 1ns / 1ps

module tb_top;
  import hrbm_pkg::*;

  localparam int SAMPLE_W = 12;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int RATE_SLOTS = 8;
  localparam int GAP_MAX = 13;
  localparam int BEAT_CYCLES = 42;
  localparam int SETTLE_CYCLES = 2 * BEAT_CYCLES;
  localparam longint CYCLE_LIMIT = 500_000;
  localparam int LONG_RUN = 300;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int TIGHT_PERIOD = 10;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5    = 3'd5;

  localparam int DEF_HIGH_THR   = 2148;
  localparam int DEF_LOW_THR    = 1948;
  localparam int DEF_ALARM_LOW  = 30;
  localparam int DEF_ALARM_HIGH = 130;
  localparam int DEF_RATE_NUM   = 30000;

  localparam int unsigned BPM_60  = 60;
  localparam int unsigned BPM_90  = 90;
  localparam int unsigned BPM_130 = 130;
  localparam int unsigned BPM_170 = 170;
  localparam int unsigned BPM_190 = 190;

  localparam logic [RATE_W-1:0] PSC_SLOWEST = 16'd63999;
  localparam logic [RATE_W-1:0] PSC_SLOW    = 16'd31999;
  localparam logic [RATE_W-1:0] PSC_MID     = 16'd21332;
  localparam logic [RATE_W-1:0] PSC_FAST    = 16'd15999;
  localparam logic [RATE_W-1:0] PSC_FASTER  = 16'd12799;
  localparam logic [RATE_W-1:0] PSC_FASTEST = 16'd10666;
  localparam logic [CMP_W-1:0]  CMP_NORMAL  = 10'd500;
  localparam logic [CMP_W-1:0]  CMP_ALARM   = 10'd1000;

  typedef enum logic [1:0] {
    WAIT_RISE,
    WAIT_FALL,
    COUNT_LOW,
    COUNT_HIGH
  } det_phase_t;

  typedef struct packed {
    logic [RATE_W-1:0] bpm;
    logic              beat;
    logic              pwm_update;
    logic [RATE_W-1:0] pwm_prescaler;
    logic [CMP_W-1:0]  pwm_compare;
    logic              alarm;
  } meter_result_t;

  class beat_rate_scoreboard;
    logic [SAMPLE_W-1:0] hi_thr;
    logic [SAMPLE_W-1:0] lo_thr;
    logic [7:0]          al_low;
    logic [7:0]          al_high;
    logic [15:0]         numer;
    det_phase_t          phase;
    logic [COUNT_W-1:0]  period;
    logic [RATE_W-1:0]   rates [RATE_SLOTS];
    logic [2:0]          slot;
    meter_result_t       pending [$];
    int                  mismatches;

    function new();
      hi_thr = SAMPLE_W'(DEF_HIGH_THR);
      lo_thr = SAMPLE_W'(DEF_LOW_THR);
      al_low = 8'(DEF_ALARM_LOW);
      al_high = 8'(DEF_ALARM_HIGH);
      numer = 16'(DEF_RATE_NUM);
      phase = WAIT_RISE;
      period = '0;
      slot = '0;
      mismatches = 0;
      foreach (rates[i]) rates[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HIGH_THR:   hi_thr = data[SAMPLE_W-1:0];
        REG_LOW_THR:    lo_thr = data[SAMPLE_W-1:0];
        REG_ALARM_LOW:  al_low = data[7:0];
        REG_ALARM_HIGH: al_high = data[7:0];
        REG_RATE_NUM:   numer = data;
        default: ;
      endcase
    endfunction

    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s);
      meter_result_t r;
      int unsigned   sum;
      int unsigned   avg;
      r = '0;
      sum = 0;
      case (phase)
        WAIT_RISE: if (s > hi_thr) phase = WAIT_FALL;
        WAIT_FALL: if (s < lo_thr) begin
          phase = COUNT_LOW;
          period = '0;
        end
        COUNT_LOW: begin
          period = bump(period);
          if (s > hi_thr) phase = COUNT_HIGH;
        end
        default: begin
          period = bump(period);
          if (s < lo_thr) begin
            phase = COUNT_LOW;
            rates[slot] = RATE_W'(numer / period);
            slot = slot + 1'b1;
            period = '0;
            r.beat = 1'b1;
          end
        end
      endcase
      foreach (rates[i]) sum += rates[i];
      avg = sum / RATE_SLOTS;
      r.bpm = RATE_W'(avg);
      if (avg > al_high) begin
        r.pwm_update = 1'b1;
        r.pwm_prescaler = PSC_FASTEST;
        r.pwm_compare = CMP_ALARM;
        r.alarm = 1'b1;
      end else begin
        if (avg + 1 >= al_low && avg < BPM_60) r.pwm_prescaler = PSC_SLOWEST;
        else if (avg >= BPM_60 && avg < BPM_90) r.pwm_prescaler = PSC_SLOW;
        else if (avg > BPM_90 && avg <= BPM_130) r.pwm_prescaler = PSC_MID;
        else if (avg > BPM_130 && avg <= BPM_170) r.pwm_prescaler = PSC_FAST;
        else if (avg > BPM_170 && avg <= BPM_190) r.pwm_prescaler = PSC_FASTER;
        else if (avg > BPM_190) r.pwm_prescaler = PSC_FASTEST;
        if (r.pwm_prescaler != '0) begin
          r.pwm_update = 1'b1;
          r.pwm_compare = CMP_NORMAL;
        end
      end
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [RATE_W-1:0] want, logic [RATE_W-1:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(meter_result_t got);
      meter_result_t want;
      if (pending.size() == 0) begin
        $error("result arrived with no sample waiting, bpm %0d", got.bpm);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("bpm", want.bpm, got.bpm);
      compare_field("beat", want.beat, got.beat);
      compare_field("pwm_update", want.pwm_update, got.pwm_update);
      compare_field("pwm_prescaler", want.pwm_prescaler, got.pwm_prescaler);
      compare_field("pwm_compare", want.pwm_compare, got.pwm_compare);
      compare_field("alarm", want.alarm, got.alarm);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  bit                    idle_on;
  longint                cycles = 0;
  beat_rate_scoreboard   sb;

  hrbm_sample_if #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();
  hrbm_result_if                           result_ch ();

  heart_rate_beat_meter #(
    .RING_DEPTH  (RATE_SLOTS),
    .SAMPLE_BITS (SAMPLE_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_ch),
    .results  (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] level_low();
    if (sb.lo_thr == '0) return '0;
    return SAMPLE_W'($urandom_range(int'(sb.lo_thr) - 1, 0));
  endfunction

  function automatic logic [SAMPLE_W-1:0] level_high();
    if (sb.hi_thr == SAMPLE_W'(SAMPLE_MAX)) return SAMPLE_W'(SAMPLE_MAX);
    return SAMPLE_W'($urandom_range(SAMPLE_MAX, int'(sb.hi_thr) + 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] level_mid();
    if (sb.lo_thr <= sb.hi_thr) return SAMPLE_W'($urandom_range(sb.hi_thr, sb.lo_thr));
    return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = idle_on ? $urandom_range(GAP_MAX, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.take_sample(s);
  endtask

  task automatic drain_results();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic apply_setting(input int hi, input int lo, input int alow, input int ahigh,
                               input int num);
    drain_results();
    write_reg(REG_HIGH_THR, {4'($urandom), SAMPLE_W'(hi)});
    write_reg(REG_LOW_THR, {4'($urandom), SAMPLE_W'(lo)});
    write_reg(REG_ALARM_LOW, {8'($urandom), 8'(alow)});
    write_reg(REG_ALARM_HIGH, {8'($urandom), 8'(ahigh)});
    write_reg(REG_RATE_NUM, 16'(num));
    // unused index, must leave everything alone
    write_reg(REG_SPARE_5 + CFG_IDX_W'($urandom_range(2, 0)), 16'($urandom));
  endtask

  task automatic send_pulse(input int lo_len, input int hi_len);
    repeat (lo_len) push_sample(($urandom_range(19, 0) == 0) ? level_mid() : level_low());
    repeat (hi_len) push_sample(($urandom_range(19, 0) == 0) ? level_mid() : level_high());
  endtask

  task automatic run_random_phase(input int items, input int base_period);
    int sent;
    int kind;
    int p;
    int lo_len;
    int n;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(99, 0);
      if (kind < 80) begin
        p = base_period + $urandom_range(2, 0) - 1;
        if (p < 2) p = 2;
        lo_len = $urandom_range(p - 1, 1);
        send_pulse(lo_len, p - lo_len);
        sent += p;
      end else if (kind < 90) begin
        n = $urandom_range(6, 1);
        repeat (n) push_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)));
        sent += n;
      end else if (kind < 98) begin
        // broken pulse: a rise that dwells in the dead band
        n = $urandom_range(4, 1);
        push_sample(level_high());
        repeat (n) push_sample(level_mid());
        sent += n + 1;
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    int k;
    int p;
    int t;
    int lo;
    int hi;
    int num;
    int ahigh;
    sb = new();
    rst = 1'b1;
    idle_on = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // threshold edges, fall from counting-high on a zero sample, shortest period
    idle_on = 1'b1;
    push_sample('0);
    push_sample(SAMPLE_W'(DEF_HIGH_THR));
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(SAMPLE_W'(DEF_LOW_THR));
    push_sample(SAMPLE_W'(DEF_LOW_THR + 1));
    push_sample('0);
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample('0);
    push_sample(SAMPLE_W'(DEF_HIGH_THR + 1));
    push_sample(SAMPLE_W'(DEF_LOW_THR - 1));
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(12'h555);
    push_sample(12'haaa);
    push_sample('0);

    // steady pulse train that settles the average on exactly 90
    apply_setting(DEF_HIGH_THR, DEF_LOW_THR, DEF_ALARM_LOW, DEF_ALARM_HIGH,
                  BPM_90 * TIGHT_PERIOD);
    push_sample(level_high());
    push_sample(level_low());
    repeat (10) send_pulse(TIGHT_PERIOD / 2, TIGHT_PERIOD / 2);

    // long period at full numerator
    apply_setting(DEF_HIGH_THR, DEF_LOW_THR, 1, 255, 65535);
    idle_on = 1'b0;
    push_sample(level_high());
    push_sample(level_low());
    repeat (LONG_RUN) push_sample(level_low());
    push_sample(level_high());
    push_sample(level_low());

    // unreachable thresholds, alarm on any nonzero average
    apply_setting(SAMPLE_MAX, 0, 255, 0, 1);
    idle_on = 1'b1;
    repeat (40) push_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)));

    // inverted thresholds, zero numerator, first band reaching down to zero
    apply_setting(0, SAMPLE_MAX, 0, 255, 0);
    repeat (60) push_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)));
    push_sample('0);
    push_sample(SAMPLE_W'(SAMPLE_MAX));

    for (k = 0; k < RANDOM_PHASES; k++) begin
      lo = $urandom_range(3000, 200);
      hi = lo + $urandom_range(800, 0);
      if (hi > 4000) hi = 4000;
      p = $urandom_range(24, 2);
      t = $urandom_range(260, 0);
      num = t * p;
      if (num < 1) num = 1;
      if (num > 65535) num = 65535;
      ahigh = (k % 4 == 0) ? $urandom_range(99, 0) : $urandom_range(255, 100);
      apply_setting(hi, lo, $urandom_range(120, 1), ahigh, num);
      idle_on = (k % 3) != 2;
      run_random_phase(ITEMS_PER_PHASE, p);
    end

    drain_results();
    if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    meter_result_t got;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(GAP_MAX, 0) : 0;
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      got.bpm = result_ch.bpm;
      got.beat = result_ch.beat;
      got.pwm_update = result_ch.pwm_update;
      got.pwm_prescaler = result_ch.pwm_prescaler;
      got.pwm_compare = result_ch.pwm_compare;
      got.alarm = result_ch.alarm;
      sb.match_result(got);
      @(negedge clk);
    end
  end

endmodule
